[rtl/core/hecspmv_pkg.sv]
`default_nettype none

package hecspmv_pkg;

  // Defaults for the top-level parameters.
  localparam int MAX_ROWS_DEF      = 1024;
  localparam int MAX_COLS_DEF      = 1024;
  localparam int ELL_MAX_WIDTH_DEF = 32;

  // Field widths fixed by the item formats.
  localparam int ROW_W   = 10;
  localparam int COL_W   = 10;
  localparam int VAL_W   = 32;
  localparam int IDX_W   = 20;
  localparam int SUM_W   = 64;
  localparam int ELLW_W  = 6;
  localparam int NCOLS_W = 11;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 11;

  // The vector store never needs more entries than a column field can address.
  localparam int VEC_DEPTH_MAX = 1 << COL_W;

  localparam logic [ELLW_W-1:0]  ELL_WIDTH_RST = 6'd20;
  localparam logic [NCOLS_W-1:0] NUM_COLS_RST  = 11'd1024;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ELL_WIDTH = 1'b0,
    REG_NUM_COLS  = 1'b1
  } cfg_reg_t;

  typedef enum logic {
    OP_VEC_LOAD = 1'b0,
    OP_MATRIX   = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    KIND_ELL = 2'd0,
    KIND_PAD = 2'd1,
    KIND_COO = 2'd2,
    KIND_SUM = 2'd3
  } kind_t;

  typedef struct packed {
    logic               opcode;
    logic [ROW_W-1:0]   row;
    logic [COL_W-1:0]   col;
    logic signed [VAL_W-1:0] value;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]              kind;
    logic [IDX_W-1:0]        entry_index;
    logic [ROW_W-1:0]        out_row;
    logic [COL_W-1:0]        column;
    logic signed [VAL_W-1:0] entry_value;
    logic signed [SUM_W-1:0] row_sum;
    logic                    last;
  } out_beat_t;

endpackage

`default_nettype wire

[rtl/core/hybrid_ell_coo_spmv_unit.sv]
`default_nettype none

// Channel   Direction  Handshake           Payload
// in_       input      in_valid / in_stall   in_data   (in_beat_t)
// out_      output     out_valid / out_stall out_data  (out_beat_t)
// cfg_      input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// A vector-load beat is taken and the next beat may follow at once. A matrix beat
// passes through accept, vector read and multiply then add; a stored nonzero then
// gives its entry beat, and at a row end one beat per padding slot and one for
// the row sum follow. The vector memory read is registered, and the registered
// 32x32 multiplier lies ahead of the 64-bit saturating add. Reset is synchronous
// and active low; it clears the row state, the COO counter and the output valid
// flag and loads the configuration defaults, but not the vector memory. A stalled
// output holds the current result beat; the sequencer waits, and the input stays
// stalled until the item's last result is loaded into the output register.

module hybrid_ell_coo_spmv_unit
  import hecspmv_pkg::*;
#(
  parameter int MAX_ROWS      = MAX_ROWS_DEF,
  parameter int MAX_COLS      = MAX_COLS_DEF,
  parameter int ELL_MAX_WIDTH = ELL_MAX_WIDTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire in_beat_t              in_data,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output out_beat_t                  out_data,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  // The vector memory holds one entry per addressable column below MAX_COLS.
  localparam int VD = (MAX_COLS < VEC_DEPTH_MAX) ? MAX_COLS : VEC_DEPTH_MAX;
  localparam int AW = (VD > 1) ? $clog2(VD) : 1;
  // Slot counter must hold ELL_MAX_WIDTH itself.
  localparam int SW = $clog2(ELL_MAX_WIDTH + 1);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_RD   = 5'b00010,
    S_ACC  = 5'b00100,
    S_ENT  = 5'b01000,
    S_PAD  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  logic [ELLW_W-1:0]  ell_width_r;
  logic [NCOLS_W-1:0] num_cols_r;

  logic signed [VAL_W-1:0] vec_mem [VD];
  logic signed [VAL_W-1:0] rd_data_r;

  in_beat_t                item_r;
  logic signed [SUM_W-1:0] prod_r;
  logic signed [SUM_W-1:0] acc_r, acc_nxt;
  logic [SW-1:0]           slots_r, slots_nxt;
  logic [IDX_W-1:0]        coo_r, coo_nxt;

  out_beat_t out_r, out_nxt;
  logic      out_valid_r;
  logic      out_load;

  logic in_acc, is_vec, is_mat, row_ok, col_ok_in, col_ok_item;
  logic out_free;
  logic [6:0]        width7;
  logic [SW-1:0]     width_eff;
  logic [31:0]       cols_eff;
  logic              row_end;
  logic              nz;
  logic signed [VAL_W-1:0] x_val;
  logic signed [SUM_W-1:0] sum_raw;
  logic signed [SUM_W-1:0] sum_sat;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign in_acc      = in_valid && !in_stall;
  assign is_vec      = (in_data.opcode == OP_VEC_LOAD);
  assign is_mat      = (in_data.opcode == OP_MATRIX);
  assign row_ok      = (32'(in_data.row) < 32'(MAX_ROWS));
  assign col_ok_in   = (32'(in_data.col) < 32'(MAX_COLS));
  assign col_ok_item = (32'(item_r.col) < 32'(MAX_COLS));
  assign out_free    = !out_valid_r || !out_stall;

  // ELL width, cols used; user changes configuration only while idle, unchecked.
  assign width7    = (7'(ell_width_r) > 7'(ELL_MAX_WIDTH)) ? 7'(ELL_MAX_WIDTH)
                                                           : 7'(ell_width_r);
  assign width_eff = SW'(width7);
  assign cols_eff  = (num_cols_r == '0) ? 32'd1 :
                     ((32'(num_cols_r) > 32'(MAX_COLS)) ? 32'(MAX_COLS)
                                                       : 32'(num_cols_r));
  assign row_end   = (32'(item_r.col) == (cols_eff - 32'd1));
  assign nz        = (item_r.value != '0);

  // A column beyond the store reads as zero.
  assign x_val = col_ok_item ? rd_data_r : '0;

  // Saturating Q32.32 accumulate: overflow only when both signs agree.
  assign sum_raw = acc_r + prod_r;
  always_comb begin
    sum_sat = sum_raw;
    if (!acc_r[SUM_W-1] && !prod_r[SUM_W-1] && sum_raw[SUM_W-1]) begin
      sum_sat = {1'b0, {(SUM_W-1){1'b1}}};
    end else if (acc_r[SUM_W-1] && prod_r[SUM_W-1] && !sum_raw[SUM_W-1]) begin
      sum_sat = {1'b1, {(SUM_W-1){1'b0}}};
    end
  end

  // Vector memory: written by vector-load beats, read at the accept of a
  // matrix beat so the data is ready in the next cycle.
  always_ff @(posedge clk) begin
    if (in_acc && is_vec && col_ok_in) begin
      vec_mem[in_data.col[AW-1:0]] <= in_data.value;
    end
    if (in_acc && is_mat) begin
      rd_data_r <= vec_mem[in_data.col[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      item_r <= in_data;
    end
    if (state_r == S_RD) begin
      prod_r <= SUM_W'(item_r.value) * SUM_W'(x_val);
    end
  end

  // Sequencer: one result beat per cycle into the output register when it
  // is free, entry first, then padding slots, then the row sum.
  always_comb begin
    state_nxt = state_r;
    acc_nxt   = acc_r;
    slots_nxt = slots_r;
    coo_nxt   = coo_r;
    out_load  = 1'b0;
    out_nxt   = out_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc && is_mat && row_ok) begin
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        state_nxt = S_ACC;
      end
      S_ACC: begin
        if (nz) begin
          acc_nxt   = sum_sat;
          state_nxt = S_ENT;
        end else if (row_end) begin
          state_nxt = S_PAD;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_ENT: begin
        if (out_free) begin
          out_load            = 1'b1;
          out_nxt.out_row     = item_r.row;
          out_nxt.column      = item_r.col;
          out_nxt.entry_value = item_r.value;
          out_nxt.row_sum     = '0;
          out_nxt.last        = !row_end;
          if (slots_r < width_eff) begin
            out_nxt.kind        = KIND_ELL;
            out_nxt.entry_index = IDX_W'(slots_r);
            slots_nxt           = slots_r + SW'(1);
          end else begin
            out_nxt.kind        = KIND_COO;
            out_nxt.entry_index = coo_r;
            coo_nxt             = coo_r + IDX_W'(1);
          end
          state_nxt = row_end ? S_PAD : S_IDLE;
        end
      end
      S_PAD: begin
        if (out_free) begin
          out_load            = 1'b1;
          out_nxt.out_row     = item_r.row;
          out_nxt.column      = '0;
          out_nxt.entry_value = '0;
          if (slots_r < width_eff) begin
            out_nxt.kind        = KIND_PAD;
            out_nxt.entry_index = IDX_W'(slots_r);
            out_nxt.row_sum     = '0;
            out_nxt.last        = 1'b0;
            slots_nxt           = slots_r + SW'(1);
          end else begin
            out_nxt.kind        = KIND_SUM;
            out_nxt.entry_index = '0;
            out_nxt.row_sum     = acc_r;
            out_nxt.last        = 1'b1;
            acc_nxt             = '0;
            slots_nxt           = '0;
            state_nxt           = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      acc_r       <= '0;
      slots_r     <= '0;
      coo_r       <= '0;
      out_valid_r <= 1'b0;
      ell_width_r <= ELL_WIDTH_RST;
      num_cols_r  <= NUM_COLS_RST;
    end else begin
      state_r <= state_nxt;
      acc_r   <= acc_nxt;
      slots_r <= slots_nxt;
      coo_r   <= coo_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_ELL_WIDTH: ell_width_r <= cfg_data[ELLW_W-1:0];
          REG_NUM_COLS:  num_cols_r  <= cfg_data[NCOLS_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_r <= out_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_slots_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(slots_r) <= 32'(ELL_MAX_WIDTH))
    else $error("ELL slot count exceeds the maximum width");

  a_sum_clears_row: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && out_nxt.kind == KIND_SUM) |=> (acc_r == '0 && slots_r == '0))
    else $error("row state not cleared after row sum");

  a_mat_starts_read: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && is_mat && row_ok) |=> (state_r == S_RD))
    else $error("matrix beat did not start a vector read");

  a_vec_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && is_vec) |=> (state_r == S_IDLE && !out_load))
    else $error("vector load caused work or a result");

  a_load_only_free: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> !out_load)
    else $error("result loaded over a stalled beat");
`endif

endmodule

`default_nettype wire
